// ===== hw/rtl/wbii_pkg.sv =====
package wbii_pkg;

    // Grid geometry
    localparam int GRID_COLS = 32;
    localparam int GRID_ROWS = 32;
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int CELL_SHIFT = $clog2(GRID_COLS);

    // Field and datapath widths
    localparam int SIZE_W   = 15;                      // frame size register
    localparam int D1_W     = SIZE_W - CELL_SHIFT;     // size / 32
    localparam int WGT_W    = D1_W + 1;                // weight, up to d1 + 1
    localparam int POS_W    = SIZE_W + ROW_W;          // size * index
    localparam int BOX_W    = 32;
    localparam int PROD_W   = BOX_W + 2 * WGT_W;       // box * row weight * col weight
    localparam int HALF_W   = PROD_W / 2;
    localparam int VALUE_W  = 64;
    localparam int DH_W     = D1_W + WGT_W;            // d1 * d2 for one axis
    localparam int DEN_W    = 2 * DH_W;                // full denominator

    // Precision factors
    localparam int FACTOR_W = 29;
    localparam logic [FACTOR_W-1:0] FACTOR_FINE = FACTOR_W'(476985600);
    localparam int COARSE_SHIFT = $clog2(65536);
    localparam int SCALED_W = HALF_W + FACTOR_W;

    // Divider sequencing
    localparam int DIV_CNT_W = $clog2(VALUE_W);

    // Queue between the front and the back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Output packing
    localparam int OUT_DATA_W = ((VALUE_W + ROW_W + COL_W + 7) / 8) * 8;

    // Register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_ROUNDING_MODE = 2'd2
    } reg_idx_t;

    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = SIZE_W'(1920);
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = SIZE_W'(1080);

    typedef struct packed {
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
        logic              rounding_mode;
    } cfg_t;

    // One classified item as it travels from front to back
    typedef struct packed {
        logic [BOX_W-1:0] box_sum;
        logic [WGT_W-1:0] wgt_row;
        logic [WGT_W-1:0] wgt_col;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } item_t;

    // Second block size: d1 + 1 when size is not a multiple of the grid, else 1
    function automatic logic [WGT_W-1:0] size_hi(input logic [SIZE_W-1:0] size);
        logic [D1_W-1:0] d1;
        d1 = size[SIZE_W-1:CELL_SHIFT];
        if (size[CELL_SHIFT-1:0] != '0)
            return WGT_W'(d1) + WGT_W'(1);
        else
            return WGT_W'(1);
    endfunction

    // Weight of one grid line; pos is size * index
    function automatic logic [WGT_W-1:0] line_weight(input logic [SIZE_W-1:0] size,
                                                     input logic [POS_W-1:0]  pos);
        logic [D1_W-1:0]  d1;
        logic [POS_W:0]   lo;
        logic [POS_W:0]   hi;
        logic [POS_W:0]   len;
        d1  = size[SIZE_W-1:CELL_SHIFT];
        lo  = ((POS_W+1)'(pos) + (POS_W+1)'(GRID_COLS - 1)) >> CELL_SHIFT;
        hi  = ((POS_W+1)'(pos) + (POS_W+1)'(size) + (POS_W+1)'(GRID_COLS - 1)) >> CELL_SHIFT;
        len = hi - lo;
        if (size[CELL_SHIFT-1:0] == '0 || d1 == '0)
            return WGT_W'(1);
        else if (len == (POS_W+1)'(d1))
            return WGT_W'(d1) + WGT_W'(1);
        else
            return WGT_W'(d1);
    endfunction

endpackage

// ===== hw/rtl/weighted_block_integral_image.sv =====
// Weighted summed-area table over a 32x32 block grid. Each transaction on the
// s_ side carries one block pixel sum in raster order; each m_ transaction
// carries the matching table cell (mod 2^64) with its row and column, and
// tlast marks the final cell of the grid. Blocks are weighted by the opposite
// block height and width implied by frame_width / frame_height, scaled by
// 476985600 (rounding_mode 0) or by 65536 and divided by d1h*d2h*d1w*d2w
// (rounding_mode 1). A front stage classifies each sum and computes its
// weights, a 4-entry queue decouples it from a sequencer that does the
// arithmetic for one cell at a time. A cell takes two multiplies plus a
// two-half scale by the fine factor with rounding_mode 0, and a radix-2
// division for the 64-bit quotient with rounding_mode 1. Register writes
// are to be made while no cell is in flight.
module weighted_block_integral_image
    import wbii_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BOX_W-1:0]      s_tdata,   // [31:0] box_sum

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [63:0] table_value, [68:64] cell_row,
                                             // [73:69] cell_col, [79:74] zero
    output logic                  m_tlast    // frame_done
);

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_sel;
    logic     cfg_write;

    item_t    push_item;
    item_t    head_item;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;

    // Register port
    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_sel)
                REG_FRAME_WIDTH:   cfg_next.frame_width   = pwdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT:  cfg_next.frame_height  = pwdata[SIZE_W-1:0];
                REG_ROUNDING_MODE: cfg_next.rounding_mode = pwdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_FRAME_WIDTH:   prdata = APB_DATA_W'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT:  prdata = APB_DATA_W'(cfg_reg.frame_height);
            REG_ROUNDING_MODE: prdata = APB_DATA_W'(cfg_reg.rounding_mode);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width   <= FRAME_WIDTH_RST;
            cfg_reg.frame_height  <= FRAME_HEIGHT_RST;
            cfg_reg.rounding_mode <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Classifier
    wbii_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // Decoupling queue
    wbii_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (head_item),
        .empty     (q_empty)
    );

    // Arithmetic sequencer and table store
    wbii_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_item   (head_item),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // The back never takes an item that is not in the queue
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // The front never pushes into a full queue
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue pushed while full");

    // The frame marker only rides on the bottom-right cell
    a_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |->
            m_tdata[VALUE_W+ROW_W-1:VALUE_W] == ROW_W'(GRID_ROWS - 1) &&
            m_tdata[VALUE_W+ROW_W+COL_W-1:VALUE_W+ROW_W] == COL_W'(GRID_COLS - 1))
        else $error("frame_done on a cell that is not the last");
`endif

endmodule

// ===== hw/rtl/wbii_front.sv =====
module wbii_front
    import wbii_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BOX_W-1:0]  s_tdata,     // box_sum
    input  logic              q_full,
    output logic              q_push,
    output item_t             q_item
);

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] pos_row;
    logic [POS_W-1:0] pos_col;
    logic             at_last_col;
    logic             at_last_row;

    // Handshake: take an item whenever the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Position of the current block along each axis
    assign pos_row = POS_W'(cfg.frame_height) * POS_W'(row_reg);
    assign pos_col = POS_W'(cfg.frame_width) * POS_W'(col_reg);

    assign at_last_col = (col_reg == COL_W'(GRID_COLS - 1));
    assign at_last_row = (row_reg == ROW_W'(GRID_ROWS - 1));

    // Classified item
    always_comb
    begin
        q_item.box_sum = s_tdata;
        q_item.wgt_row = line_weight(cfg.frame_height, pos_row);
        q_item.wgt_col = line_weight(cfg.frame_width, pos_col);
        q_item.row     = row_reg;
        q_item.col     = col_reg;
        q_item.last    = at_last_row && at_last_col;
    end

    // Raster position, wraps at the end of the grid
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (q_push)
        begin
            if (at_last_col)
            begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

// ===== hw/rtl/wbii_queue.sv =====
module wbii_queue
    import wbii_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slots_reg[rd_ptr_reg];

    // Pointer and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== hw/rtl/wbii_back.sv =====
module wbii_back
    import wbii_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  item_t                 q_item,
    input  logic                  q_empty,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // table_value, cell_row, cell_col, zero pad
    output logic                  m_tlast    // frame_done
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_MUL_A    = 8'b0000_0010,
        ST_MUL_B    = 8'b0000_0100,
        ST_SCALE    = 8'b0000_1000,
        ST_SCALE_HI = 8'b0001_0000,
        ST_DIV      = 8'b0010_0000,
        ST_ROW      = 8'b0100_0000,
        ST_CELL     = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    item_t                 item_reg, item_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [VALUE_W-1:0]    term_reg, term_next;
    logic [DEN_W-1:0]      rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VALUE_W-1:0]    row_sum_reg, row_sum_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;

    logic [VALUE_W-1:0]    col_mem [GRID_COLS];
    logic [VALUE_W-1:0]    rd_data_reg;
    logic                  mem_we;
    logic [VALUE_W-1:0]    cell_value;

    logic [DH_W-1:0]       dh_reg;
    logic [DH_W-1:0]       dw_reg;
    logic [DEN_W-1:0]      den_prod_reg;
    logic [DEN_W-1:0]      den_reg;

    logic [SCALED_W-1:0]   lo_scaled;
    logic [SCALED_W-1:0]   hi_scaled;
    logic [DEN_W:0]        div_shift;
    logic [DEN_W:0]        div_diff;
    logic                  div_fits;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Denominator for the coarse mode, follows the frame size registers
    always_ff @(posedge clk)
    begin
        dh_reg       <= DH_W'(cfg.frame_height[SIZE_W-1:CELL_SHIFT]) * DH_W'(size_hi(cfg.frame_height));
        dw_reg       <= DH_W'(cfg.frame_width[SIZE_W-1:CELL_SHIFT]) * DH_W'(size_hi(cfg.frame_width));
        den_prod_reg <= DEN_W'(dh_reg) * DEN_W'(dw_reg);
        den_reg      <= (den_prod_reg == '0) ? DEN_W'(1) : den_prod_reg;
    end

    // Fine factor applied to each half of the weighted sum
    assign lo_scaled = SCALED_W'(prod_reg[HALF_W-1:0]) * SCALED_W'(FACTOR_FINE);
    assign hi_scaled = SCALED_W'(prod_reg[PROD_W-1:HALF_W]) * SCALED_W'(FACTOR_FINE);

    // One restoring division step
    assign div_shift = {rem_reg, term_reg[VALUE_W-1]};
    assign div_fits  = (div_shift >= {1'b0, den_reg});
    assign div_diff  = div_shift - {1'b0, den_reg};

    // Table cell: row sum plus column total from the row above
    assign cell_value = (item_reg.row == '0) ? row_sum_reg : rd_data_reg + row_sum_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        prod_next      = prod_reg;
        term_next      = term_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        row_sum_next   = row_sum_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                prod_next  = PROD_W'(item_reg.box_sum) * PROD_W'(item_reg.wgt_row);
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                prod_next  = PROD_W'(prod_reg[BOX_W+WGT_W-1:0]) * PROD_W'(item_reg.wgt_col);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (cfg.rounding_mode)
                begin
                    term_next  = {prod_reg[VALUE_W-COARSE_SHIFT-1:0], {COARSE_SHIFT{1'b0}}};
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    term_next  = VALUE_W'(lo_scaled);
                    state_next = ST_SCALE_HI;
                end
            end
            ST_SCALE_HI:
            begin
                term_next  = term_reg + {hi_scaled[VALUE_W-HALF_W-1:0], {HALF_W{1'b0}}};
                state_next = ST_ROW;
            end
            ST_DIV:
            begin
                term_next = {term_reg[VALUE_W-2:0], div_fits};
                rem_next  = div_fits ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
                cnt_next  = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(VALUE_W - 1))
                    state_next = ST_ROW;
            end
            ST_ROW:
            begin
                row_sum_next = ((item_reg.col == '0) ? '0 : row_sum_reg) + term_reg;
                state_next   = ST_CELL;
            end
            ST_CELL:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    mem_we         = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_DATA_W'({item_reg.col, item_reg.row, cell_value});
                    out_last_next  = item_reg.last;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            row_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            row_sum_reg   <= row_sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        term_reg     <= term_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // Column totals, one entry per grid column
    always_ff @(posedge clk)
    begin
        if (mem_we)
            col_mem[item_reg.col] <= cell_value;
        rd_data_reg <= col_mem[item_reg.col];
    end

endmodule
